FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau assertion failed");

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cau assertion failed");

`endif

FILE: src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Command codes and control types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int CMD_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_NEG  = 3'd4,
    CMD_MAGL = 3'd5,
    CMD_EQ   = 3'd6
  } cau_cmd_t;

  typedef struct packed {
    logic arith;   // result parts carry a value
    logic is_div;  // value comes from the quotient lanes
    logic cmp;     // compare outcome
    logic dz;      // zero divisor
  } cau_ctl_t;

endpackage

`default_nettype wire

FILE: src/cau_in_if.sv
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: command and two complex operands with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_in_if #(
  parameter int WORD_BITS = 32
);
  logic                               valid;
  logic                               ready;
  logic [cau_pkg::CMD_BITS-1:0]       command;
  logic signed [WORD_BITS-1:0]        a_re;
  logic signed [WORD_BITS-1:0]        a_im;
  logic signed [WORD_BITS-1:0]        b_re;
  logic signed [WORD_BITS-1:0]        b_im;

  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

FILE: src/cau_out_if.sv
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and flags with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_out_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_re;
  logic signed [WORD_BITS-1:0] res_im;
  logic                        compare_true;
  logic                        divide_by_zero;
  logic                        saturated;

  modport source (output valid, res_re, res_im, compare_true, divide_by_zero, saturated,
                  input ready);
  modport sink   (input valid, res_re, res_im, compare_true, divide_by_zero, saturated,
                  output ready);
endinterface

`default_nettype wire

FILE: src/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step #(
  parameter int WORD_BITS = 32
) (
  input  wire logic [2*WORD_BITS:0]   rem_i,
  input  wire logic                   nbit,
  input  wire logic [2*WORD_BITS-1:0] den,
  output logic      [2*WORD_BITS:0]   rem_o,
  output logic                        qbit
);
  localparam int RW = 2*WORD_BITS + 1;

  logic [RW-1:0] trial;
  logic [RW-1:0] den_x;

  // remainder stays below the divisor, so its top bit is free
  assign trial = {rem_i[RW-2:0], nbit};
  assign den_x = {1'b0, den};
  assign qbit  = (trial >= den_x);
  assign rem_o = qbit ? (trial - den_x) : trial;
endmodule

`default_nettype wire

FILE: src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Operand capture, products and sums: three elastic register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  cau_in_if.sink                        in_ch,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output cau_pkg::cau_ctl_t             dn_ctl,
  output logic signed [2*WORD_BITS+1:0] dn_vr,
  output logic signed [2*WORD_BITS+1:0] dn_vi,
  output logic [2*WORD_BITS-1:0]        dn_den
);
  localparam int W  = WORD_BITS;
  localparam int LW = WORD_BITS + 1;
  localparam int PW = 2*WORD_BITS;
  localparam int VW = 2*WORD_BITS + 2;

  logic en_a, en_b, en_c;

  // stage A: operand capture
  logic               a_v_r;
  cau_pkg::cau_cmd_t  a_cmd_r;
  logic signed [W-1:0] a_ar_r, a_ai_r, a_br_r, a_bi_r;

  // stage B: products and linear results
  logic               b_v_r;
  cau_pkg::cau_cmd_t  b_cmd_r;
  logic signed [PW-1:0] b_rr_r, b_ii_r, b_ri_r, b_ir_r, b_aa1_r, b_aa2_r, b_bb1_r, b_bb2_r;
  logic signed [LW-1:0] b_lre_r, b_lim_r, b_lre_nxt, b_lim_nxt;
  logic               b_eq_r;

  // stage C: combined values
  logic               c_v_r;
  cau_pkg::cau_ctl_t  c_ctl_r, c_ctl_nxt;
  logic signed [VW-1:0] c_vr_r, c_vi_r, c_vr_nxt, c_vi_nxt;
  logic [PW-1:0]      c_den_r, c_den_nxt;

  logic signed [VW-1:0] mul_re, mul_im;
  logic [PW-1:0]      mag_a;

  assign en_c = !c_v_r || dn_ready;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;
  assign in_ch.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_cmd_r <= cau_pkg::cau_cmd_t'(in_ch.command);
      a_ar_r  <= in_ch.a_re;
      a_ai_r  <= in_ch.a_im;
      a_br_r  <= in_ch.b_re;
      a_bi_r  <= in_ch.b_im;
    end
  end

  always_comb begin
    b_lre_nxt = '0;
    b_lim_nxt = '0;
    case (a_cmd_r)
      cau_pkg::CMD_ADD: begin
        b_lre_nxt = LW'(a_ar_r) + LW'(a_br_r);
        b_lim_nxt = LW'(a_ai_r) + LW'(a_bi_r);
      end
      cau_pkg::CMD_SUB: begin
        b_lre_nxt = LW'(a_ar_r) - LW'(a_br_r);
        b_lim_nxt = LW'(a_ai_r) - LW'(a_bi_r);
      end
      cau_pkg::CMD_NEG: begin
        b_lre_nxt = -LW'(a_ar_r);
        b_lim_nxt = -LW'(a_ai_r);
      end
      default: begin
        b_lre_nxt = '0;
        b_lim_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_cmd_r <= a_cmd_r;
      b_rr_r  <= PW'(a_ar_r) * PW'(a_br_r);
      b_ii_r  <= PW'(a_ai_r) * PW'(a_bi_r);
      b_ri_r  <= PW'(a_ar_r) * PW'(a_bi_r);
      b_ir_r  <= PW'(a_ai_r) * PW'(a_br_r);
      b_aa1_r <= PW'(a_ar_r) * PW'(a_ar_r);
      b_aa2_r <= PW'(a_ai_r) * PW'(a_ai_r);
      b_bb1_r <= PW'(a_br_r) * PW'(a_br_r);
      b_bb2_r <= PW'(a_bi_r) * PW'(a_bi_r);
      b_lre_r <= b_lre_nxt;
      b_lim_r <= b_lim_nxt;
      b_eq_r  <= (a_ar_r == a_br_r) && (a_ai_r == a_bi_r);
    end
  end

  assign mul_re = VW'(b_rr_r) - VW'(b_ii_r);
  assign mul_im = VW'(b_ri_r) + VW'(b_ir_r);
  assign mag_a  = $unsigned(b_aa1_r) + $unsigned(b_aa2_r);

  always_comb begin
    c_ctl_nxt = '0;
    c_vr_nxt  = '0;
    c_vi_nxt  = '0;
    c_den_nxt = $unsigned(b_bb1_r) + $unsigned(b_bb2_r);
    case (b_cmd_r)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_NEG: begin
        c_ctl_nxt.arith = 1'b1;
        c_vr_nxt = VW'(b_lre_r);
        c_vi_nxt = VW'(b_lim_r);
      end
      cau_pkg::CMD_MUL: begin
        c_ctl_nxt.arith = 1'b1;
        c_vr_nxt = mul_re >>> FRACTION_BITS;
        c_vi_nxt = mul_im >>> FRACTION_BITS;
      end
      cau_pkg::CMD_DIV: begin
        if (c_den_nxt == '0) begin
          c_ctl_nxt.dz = 1'b1;
        end else begin
          c_ctl_nxt.arith  = 1'b1;
          c_ctl_nxt.is_div = 1'b1;
        end
        c_vr_nxt = VW'(b_rr_r) + VW'(b_ii_r);
        c_vi_nxt = VW'(b_ir_r) - VW'(b_ri_r);
      end
      cau_pkg::CMD_MAGL: begin
        c_ctl_nxt.cmp = (mag_a < c_den_nxt);
      end
      cau_pkg::CMD_EQ: begin
        c_ctl_nxt.cmp = b_eq_r;
      end
      default: begin
        c_ctl_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_ctl_r <= c_ctl_nxt;
      c_vr_r  <= c_vr_nxt;
      c_vi_r  <= c_vi_nxt;
      c_den_r <= c_den_nxt;
    end
  end

  assign dn_valid = c_v_r;
  assign dn_ctl   = c_ctl_r;
  assign dn_vr    = c_vr_r;
  assign dn_vi    = c_vi_r;
  assign dn_den   = c_den_r;
endmodule

`default_nettype wire

FILE: src/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Pipelined fixed-point divider, two lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_ready,
  input  wire cau_pkg::cau_ctl_t        up_ctl,
  input  wire logic signed [2*WORD_BITS+1:0] up_vr,
  input  wire logic signed [2*WORD_BITS+1:0] up_vi,
  input  wire logic [2*WORD_BITS-1:0]   up_den,
  output logic                          dn_valid,
  input  wire logic                     dn_ready,
  output cau_pkg::cau_ctl_t             dn_ctl,
  output logic signed [2*WORD_BITS+1:0] dn_vr,
  output logic signed [2*WORD_BITS+1:0] dn_vi,
  output logic [1:0][WORD_BITS:0]       dn_q,
  output logic [1:0]                    dn_ovf,
  output logic [1:0]                    dn_neg
);
  localparam int W  = WORD_BITS;
  localparam int VW = 2*W + 2;
  localparam int DW = 2*W;
  localparam int RW = 2*W + 1;
  localparam int QW = W + 1;
  localparam int NW = 2*W + 1 + FRACTION_BITS;
  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic en_d, en_e;

  // stage D: magnitudes
  logic                 d_v_r;
  cau_pkg::cau_ctl_t    d_ctl_r;
  logic signed [VW-1:0] d_vr_r, d_vi_r;
  logic [DW-1:0]        d_den_r;
  logic [1:0][RW-1:0]   d_mag_r, d_mag_nxt;
  logic [1:0]           d_neg_r, d_neg_nxt;

  // stage E: overflow check and first partial remainder
  logic                 e_v_r;
  cau_pkg::cau_ctl_t    e_ctl_r;
  logic signed [VW-1:0] e_vr_r, e_vi_r;
  logic [DW-1:0]        e_den_r;
  logic [1:0][RW-1:0]   e_rem_r, e_rem_nxt;
  logic [1:0][QW-1:0]   e_nlo_r, e_nlo_nxt;
  logic [1:0]           e_neg_r, e_ovf_r, e_ovf_nxt;

  logic signed [VW-1:0] lane_v [2];
  logic [VW-1:0]        lane_mag [2];
  logic [NW-1:0]        num [2];
  logic [HW-1:0]        num_hi [2];

  // quotient stages
  logic                 s_v_r   [QW];
  logic                 s_en    [QW];
  cau_pkg::cau_ctl_t    s_ctl_r [QW];
  logic signed [VW-1:0] s_vr_r  [QW];
  logic signed [VW-1:0] s_vi_r  [QW];
  logic [DW-1:0]        s_den_r [QW];
  logic [1:0][RW-1:0]   s_rem_r [QW];
  logic [1:0][QW-1:0]   s_nlo_r [QW];
  logic [1:0][QW-1:0]   s_q_r   [QW];
  logic [1:0]           s_neg_r [QW];
  logic [1:0]           s_ovf_r [QW];

  assign lane_v[0] = up_vr;
  assign lane_v[1] = up_vi;

  assign en_e     = !e_v_r || s_en[0];
  assign en_d     = !d_v_r || en_e;
  assign up_ready = en_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      d_neg_nxt[l] = lane_v[l][VW-1];
      lane_mag[l]  = d_neg_nxt[l] ? $unsigned(-lane_v[l]) : $unsigned(lane_v[l]);
      d_mag_nxt[l] = lane_mag[l][RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en_d) begin
      d_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_ctl_r <= up_ctl;
      d_vr_r  <= up_vr;
      d_vi_r  <= up_vi;
      d_den_r <= up_den;
      d_mag_r <= d_mag_nxt;
      d_neg_r <= d_neg_nxt;
    end
  end

  // quotient beyond QW bits always saturates; flag it up front
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      num[l]       = NW'(d_mag_r[l]) << FRACTION_BITS;
      num_hi[l]    = num[l][NW-1:QW];
      e_ovf_nxt[l] = (CW'(num_hi[l]) >= CW'(d_den_r));
      e_rem_nxt[l] = e_ovf_nxt[l] ? '0 : RW'(num_hi[l]);
      e_nlo_nxt[l] = num[l][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en_e) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_ctl_r <= d_ctl_r;
      e_vr_r  <= d_vr_r;
      e_vi_r  <= d_vi_r;
      e_den_r <= d_den_r;
      e_rem_r <= e_rem_nxt;
      e_nlo_r <= e_nlo_nxt;
      e_neg_r <= d_neg_r;
      e_ovf_r <= e_ovf_nxt;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 p_v;
    cau_pkg::cau_ctl_t    p_ctl;
    logic signed [VW-1:0] p_vr, p_vi;
    logic [DW-1:0]        p_den;
    logic [1:0][RW-1:0]   p_rem, rem_o;
    logic [1:0][QW-1:0]   p_nlo, p_q;
    logic [1:0]           p_neg, p_ovf, qb;

    if (k == 0) begin : g_first
      assign p_v   = e_v_r;
      assign p_ctl = e_ctl_r;
      assign p_vr  = e_vr_r;
      assign p_vi  = e_vi_r;
      assign p_den = e_den_r;
      assign p_rem = e_rem_r;
      assign p_nlo = e_nlo_r;
      assign p_q   = '0;
      assign p_neg = e_neg_r;
      assign p_ovf = e_ovf_r;
    end else begin : g_next
      assign p_v   = s_v_r[k-1];
      assign p_ctl = s_ctl_r[k-1];
      assign p_vr  = s_vr_r[k-1];
      assign p_vi  = s_vi_r[k-1];
      assign p_den = s_den_r[k-1];
      assign p_rem = s_rem_r[k-1];
      assign p_nlo = s_nlo_r[k-1];
      assign p_q   = s_q_r[k-1];
      assign p_neg = s_neg_r[k-1];
      assign p_ovf = s_ovf_r[k-1];
    end

    if (k == QW-1) begin : g_last_en
      assign s_en[k] = !s_v_r[k] || dn_ready;
    end else begin : g_mid_en
      assign s_en[k] = !s_v_r[k] || s_en[k+1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      cau_div_step #(
        .WORD_BITS (WORD_BITS)
      ) u_step (
        .rem_i (p_rem[l]),
        .nbit  (p_nlo[l][QW-1]),
        .den   (p_den),
        .rem_o (rem_o[l]),
        .qbit  (qb[l])
      );
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[k] <= 1'b0;
      end else if (s_en[k]) begin
        s_v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (s_en[k]) begin
        s_ctl_r[k] <= p_ctl;
        s_vr_r[k]  <= p_vr;
        s_vi_r[k]  <= p_vi;
        s_den_r[k] <= p_den;
        s_neg_r[k] <= p_neg;
        s_ovf_r[k] <= p_ovf;
        for (int l = 0; l < 2; l++) begin
          s_rem_r[k][l] <= rem_o[l];
          s_nlo_r[k][l] <= p_nlo[l] << 1;
          s_q_r[k][l]   <= {p_q[l][QW-2:0], qb[l]};
        end
      end
    end
  end

  assign dn_valid = s_v_r[QW-1];
  assign dn_ctl   = s_ctl_r[QW-1];
  assign dn_vr    = s_vr_r[QW-1];
  assign dn_vi    = s_vi_r[QW-1];
  assign dn_q     = s_q_r[QW-1];
  assign dn_ovf   = s_ovf_r[QW-1];
  assign dn_neg   = s_neg_r[QW-1];
endmodule

`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide, negate, squared-magnitude
// less-than and exact equality on signed fixed-point complex operands. Fully pipelined:
// one item is accepted per cycle unless back pressure stalls it, and each result passes
// three stages for capture, products and sums, two for divider setup, one per quotient
// bit in the WORD_BITS + 1 stage restoring divider and one output stage.
// Every command travels the same pipeline, so results leave in input order. Back
// pressure stalls only stages that hold an item; bubbles close up.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Top level: front end, divider pipeline and saturating output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module complex_arithmetic_unit #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);
  localparam int W  = WORD_BITS;
  localparam int VW = 2*W + 2;
  localparam int QW = W + 1;

  localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] HALF = QW'(1) << (W-1);

  logic                 f_valid, f_ready;
  cau_pkg::cau_ctl_t    f_ctl;
  logic signed [VW-1:0] f_vr, f_vi;
  logic [2*W-1:0]       f_den;

  logic                 dv_valid, dv_ready;
  cau_pkg::cau_ctl_t    dv_ctl;
  logic signed [VW-1:0] dv_vr, dv_vi;
  logic [1:0][QW-1:0]   dv_q;
  logic [1:0]           dv_ovf, dv_neg;

  logic                 out_valid_r;
  logic [W-1:0]         res_re_r, res_im_r;
  logic                 cmp_r, dz_r, sat_r;

  logic [VW-1:0]        lane_v [2];
  logic [W-1:0]         lane_res [2];
  logic [1:0]           lane_big;
  logic [QW-1:0]        q_neg [2];
  logic [VW-W:0]        v_top [2];
  logic                 en_out;

  cau_front #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_ctl   (f_ctl),
    .dn_vr    (f_vr),
    .dn_vi    (f_vi),
    .dn_den   (f_den)
  );

  cau_div #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_ctl   (f_ctl),
    .up_vr    (f_vr),
    .up_vi    (f_vi),
    .up_den   (f_den),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_ctl   (dv_ctl),
    .dn_vr    (dv_vr),
    .dn_vi    (dv_vi),
    .dn_q     (dv_q),
    .dn_ovf   (dv_ovf),
    .dn_neg   (dv_neg)
  );

  assign lane_v[0] = dv_vr;
  assign lane_v[1] = dv_vi;

  // clamp each part on its own
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_neg[l]    = -dv_q[l];
      v_top[l]    = lane_v[l][VW-1:W-1];
      lane_big[l] = 1'b0;
      lane_res[l] = '0;
      if (dv_ctl.is_div) begin
        lane_big[l] = dv_ovf[l] || (dv_neg[l] ? (dv_q[l] > HALF) : (dv_q[l] >= HALF));
        if (lane_big[l]) begin
          lane_res[l] = dv_neg[l] ? MINV : MAXV;
        end else begin
          lane_res[l] = dv_neg[l] ? q_neg[l][W-1:0] : dv_q[l][W-1:0];
        end
      end else if (dv_ctl.arith) begin
        lane_big[l] = !((v_top[l] == '0) || (v_top[l] == '1));
        if (lane_big[l]) begin
          lane_res[l] = lane_v[l][VW-1] ? MINV : MAXV;
        end else begin
          lane_res[l] = lane_v[l][W-1:0];
        end
      end
    end
  end

  assign en_out   = !out_valid_r || out_ch.ready;
  assign dv_ready = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res_re_r <= lane_res[0];
      res_im_r <= lane_res[1];
      cmp_r    <= dv_ctl.cmp;
      dz_r     <= dv_ctl.dz;
      sat_r    <= |lane_big;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_re         = res_re_r;
  assign out_ch.res_im         = res_im_r;
  assign out_ch.compare_true   = cmp_r;
  assign out_ch.divide_by_zero = dz_r;
  assign out_ch.saturated      = sat_r;

  `CAU_ASSERT_IMP(a_dz_clean, out_valid_r && dz_r, res_re_r == '0 && res_im_r == '0 && !sat_r && !cmp_r)
  `CAU_ASSERT_IMP(a_cmp_clean, out_valid_r && cmp_r, !sat_r && res_re_r == '0 && res_im_r == '0)
  `CAU_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_ch.ready)
  `CAU_ASSERT_NXT(a_drain, out_valid_r && out_ch.ready && !dv_valid, !out_valid_r)
endmodule

`default_nettype wire
